// File: design/antialiased_glyph_pixel_expander_assert.svh
// Assertion macros for the glyph pixel expander.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef ANTIALIASED_GLYPH_PIXEL_EXPANDER_ASSERT_SVH
`define ANTIALIASED_GLYPH_PIXEL_EXPANDER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset
`define AGPE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Check that an antecedent implies a consequent in the next cycle
`define AGPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AGPE_ASSERT(lbl, cond, msg)
`define AGPE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/agpe_pkg.sv
// Shared types and constants for the glyph pixel expander.
// Used by the front end, the queue, the back end and the top level.
package agpe_pkg;

  // Default color table depth
  localparam int unsigned TableEntriesDefault = 16;
  // Depth of the queue between front and back end
  localparam int unsigned QueueDepth = 2;
  // Pixels per byte at most (two bits per pixel)
  localparam int unsigned MaxPixels = 4;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 48;

  typedef enum logic {
    ActGlyph = 1'b0,
    ActLoad  = 1'b1
  } action_e;

  typedef enum logic [CfgAddrW-1:0] {
    RegPixelMode   = 3'd0,
    RegGlyphWidth  = 3'd1,
    RegGlyphHeight = 3'd2,
    RegBytesPerRow = 3'd3,
    RegOriginX     = 3'd4,
    RegOriginY     = 3'd5
  } cfg_reg_e;

  // One classified item waiting for the back end
  typedef struct packed {
    action_e                      kind;
    logic [MaxPixels-1:0]         mask;        // pixel k gives a write
    logic [MaxPixels-1:0][3:0]    pix;         // pixel indices, k = 0 leftmost
    logic [15:0]                  x_base;      // screen column of pixel 0
    logic [15:0]                  y;           // screen row
    logic [3:0]                   load_idx;
    logic [15:0]                  load_color;
  } queue_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic                 started;  // head byte partly emitted
    logic [MaxPixels-1:0] rem;      // pixels still to emit
  } back_status_t;

endpackage

// File: design/agpe_front.sv
// Front end: configuration registers, row/column counters and item classification.
// Depends on agpe_pkg.
module agpe_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [agpe_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [agpe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [agpe_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [0:0]                    s_axis_tuser_i,
  input  agpe_pkg::queue_status_t       q_status_i,
  output logic                          push_o,
  output agpe_pkg::queue_entry_t        entry_o
);
  import agpe_pkg::*;

  logic        mode_q;
  logic [7:0]  width_q;
  logic [7:0]  height_q;
  logic [7:0]  bpr_q;
  logic [15:0] ox_q;
  logic [15:0] oy_q;
  logic [6:0]  bir_q, bir_d;
  logic [7:0]  row_q, row_d;

  logic [7:0]  data_byte;
  action_e     action;
  logic        accept;
  logic [8:0]  col_base;
  logic [8:0]  col;
  logic [7:0]  next_byte;
  logic [8:0]  next_row;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !q_status_i.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_o          = accept;
  assign data_byte       = s_axis_tdata_i[7:0];
  assign action          = action_e'(s_axis_tuser_i[0]);

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= 8'd1;
      height_q <= 8'd1;
      bpr_q    <= 8'd1;
      ox_q     <= '0;
      oy_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        RegPixelMode:   mode_q   <= cfg_data_i[0];
        RegGlyphWidth:  width_q  <= cfg_data_i[7:0];
        RegGlyphHeight: height_q <= cfg_data_i[7:0];
        RegBytesPerRow: bpr_q    <= cfg_data_i[7:0];
        RegOriginX:     ox_q     <= cfg_data_i;
        RegOriginY:     oy_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify the incoming item into pixel indices and a write mask
  always_comb begin
    entry_o            = '0;
    entry_o.kind       = action;
    entry_o.load_idx   = s_axis_tdata_i[11:8];
    entry_o.load_color = s_axis_tdata_i[27:12];
    col_base           = mode_q ? {1'b0, bir_q, 1'b0} : {bir_q, 2'b00};
    if (mode_q) begin
      entry_o.pix[0] = data_byte[7:4];
      entry_o.pix[1] = data_byte[3:0];
    end else begin
      entry_o.pix[0] = {2'b00, data_byte[7:6]};
      entry_o.pix[1] = {2'b00, data_byte[5:4]};
      entry_o.pix[2] = {2'b00, data_byte[3:2]};
      entry_o.pix[3] = {2'b00, data_byte[1:0]};
    end
    for (int k = 0; k < MaxPixels; k++) begin
      col = col_base + 9'(k);
      entry_o.mask[k] = (entry_o.pix[k] != 4'd0) && (col < {1'b0, width_q});
    end
    entry_o.x_base = ox_q + 16'(col_base);
    entry_o.y      = oy_q + 16'(row_q);
  end

  // Step the byte and row counters after each glyph byte
  always_comb begin
    bir_d     = bir_q;
    row_d     = row_q;
    next_byte = {1'b0, bir_q} + 8'd1;
    next_row  = {1'b0, row_q} + 9'd1;
    if (accept && action == ActGlyph) begin
      if (next_byte >= bpr_q || next_byte[7]) begin
        bir_d = '0;
        row_d = (next_row >= {1'b0, height_q}) ? 8'd0 : next_row[7:0];
      end else begin
        bir_d = next_byte[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bir_q <= '0;
      row_q <= '0;
    end else begin
      bir_q <= bir_d;
      row_q <= row_d;
    end
  end

endmodule

// File: design/agpe_fifo.sv
// Short queue of classified items between front and back end.
// Depends on agpe_pkg for the entry and status types.
module agpe_fifo #(
  parameter int unsigned Depth = agpe_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  agpe_pkg::queue_entry_t    din_i,
  input  logic                      pop_i,
  output agpe_pkg::queue_entry_t    dout_o,
  output agpe_pkg::queue_status_t   status_o
);
  import agpe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  queue_entry_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign dout_o         = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: design/agpe_back.sv
// Back end: color table, per-pixel sequencing and the output register.
// Depends on agpe_pkg; takes items from agpe_fifo.
module agpe_back #(
  parameter int unsigned TableEntries = agpe_pkg::TableEntriesDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  agpe_pkg::queue_entry_t               head_i,
  input  agpe_pkg::queue_status_t              q_status_i,
  output logic                                 pop_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [agpe_pkg::OutDataW-1:0]        m_axis_tdata_o,
  output logic                                 m_axis_tlast_o,
  output agpe_pkg::back_status_t               status_o
);
  import agpe_pkg::*;

  localparam int unsigned AddrW = $clog2(TableEntries);

  logic [15:0]             table_q [TableEntries];
  logic [TableEntries-1:0] tvalid_q;

  logic                 started_q;
  logic [MaxPixels-1:0] rem_q;
  logic                 ovalid_q;
  logic [15:0]          x_q, y_q, color_q;
  logic                 last_q;

  logic [MaxPixels-1:0] work_mask;
  logic [MaxPixels-1:0] sel_bit;
  logic [MaxPixels-1:0] rem_next;
  logic [1:0]           sel;
  logic                 advance;
  logic                 emit;
  logic                 load;
  logic [3:0]           pix;
  logic [AddrW-1:0]     rd_addr;
  logic [AddrW-1:0]     wr_addr;
  logic                 rd_in_range;
  logic                 wr_in_range;

  // Pick the leftmost pending pixel of the head item
  always_comb begin
    work_mask = started_q ? rem_q : head_i.mask;
    advance   = !q_status_i.empty && (!ovalid_q || m_axis_tready_i);
    sel       = 2'd3;
    case (1'b1)
      work_mask[0]: sel = 2'd0;
      work_mask[1]: sel = 2'd1;
      work_mask[2]: sel = 2'd2;
      default:      sel = 2'd3;
    endcase
    sel_bit     = MaxPixels'(1) << sel;
    rem_next    = work_mask & ~sel_bit;
    load        = advance && (head_i.kind == ActLoad);
    emit        = advance && (head_i.kind == ActGlyph) && (work_mask != '0);
    pop_o       = load || (advance && (head_i.kind == ActGlyph) && (rem_next == '0));
    pix         = head_i.pix[sel];
    rd_addr     = pix[AddrW-1:0];
    wr_addr     = head_i.load_idx[AddrW-1:0];
    rd_in_range = {1'b0, pix} < 5'(TableEntries);
    wr_in_range = {1'b0, head_i.load_idx} < 5'(TableEntries);
  end

  // Write color table entries
  always_ff @(posedge clk_i) begin
    if (load && wr_in_range) begin
      table_q[wr_addr] <= head_i.load_color;
    end
  end

  // Mark entries written since reset; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= '0;
    end else if (load && wr_in_range) begin
      tvalid_q[wr_addr] <= 1'b1;
    end
  end

  // Track progress through the head byte and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      rem_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (emit) begin
        started_q <= (rem_next != '0);
        rem_q     <= rem_next;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Load the output register with one pixel write
  always_ff @(posedge clk_i) begin
    if (emit) begin
      x_q     <= head_i.x_base + 16'(sel);
      y_q     <= head_i.y;
      last_q  <= (rem_next == '0);
      color_q <= (rd_in_range && tvalid_q[rd_addr]) ? table_q[rd_addr] : 16'd0;
    end
  end

  assign m_axis_tvalid_o  = ovalid_q;
  assign m_axis_tdata_o   = {color_q, y_q, x_q};
  assign m_axis_tlast_o   = last_q;
  assign status_o.started = started_q;
  assign status_o.rem     = rem_q;

endmodule

// File: design/antialiased_glyph_pixel_expander.sv
// Glyph pixel expander: turns packed 2- or 4-bit glyph bytes into pixel writes
// colored from a loaded table. The input side takes one item per cycle while the
// two-entry queue has room; the back end keeps a glyph byte at the queue head until
// it has given all of its pixel writes (0 to 4), so the output port sets the sustained
// rate at one pixel write per cycle while ready. Each byte goes through the queue,
// then its writes leave through the output register.
// Configuration takes effect on the next byte; write it only while the block is idle.
`include "antialiased_glyph_pixel_expander_assert.svh"

module antialiased_glyph_pixel_expander #(
  parameter int unsigned TABLE_ENTRIES = agpe_pkg::TableEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [agpe_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [agpe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] data_byte, [11:8] table_index, [27:12] color_value, [31:28] zero
  input  logic [agpe_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] action
  input  logic [0:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] pixel_x, [31:16] pixel_y, [47:32] pixel_color
  output logic [agpe_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);
  import agpe_pkg::*;

  logic          push;
  logic          pop;
  queue_entry_t  entry_in;
  queue_entry_t  entry_head;
  queue_status_t q_status;
  back_status_t  b_status;

  agpe_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (entry_in)
  );

  agpe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .din_i    (entry_in),
    .pop_i    (pop),
    .dout_o   (entry_head),
    .status_o (q_status)
  );

  agpe_back #(
    .TableEntries (TABLE_ENTRIES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .head_i     (entry_head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o,
    .status_o   (b_status)
  );

  // A partly emitted byte stays at the queue head until its final write
  `AGPE_ASSERT(a_started_has_head, !b_status.started || !q_status.empty, "partial byte without queue head")
  // A partly emitted byte always has pixels left
  `AGPE_ASSERT(a_started_has_rem, !b_status.started || (b_status.rem != '0), "partial byte with no pixels left")
  // An accepted item is queued in the following cycle
  `AGPE_ASSERT_NEXT(a_accept_queued, s_axis_tvalid_i && s_axis_tready_o, !q_status.empty, "accepted item not queued")

endmodule
